>>> hw/rtl/epm_pkg.sv
package epm_pkg;

    localparam int DEF_MAX_POINTS = 64;
    localparam int DEF_COEF_BITS  = 21;

    localparam int POINT_W = 16;
    localparam int INDEX_W = 6;
    localparam int RADIUS_W = 12;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 12'd80;

    // opcodes of an input item
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    // configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_F_ROW0  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_F_ROW1  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_F_ROW2  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_RADIUS  = 2'd3;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [POINT_W-1:0] point_x;
        logic [POINT_W-1:0] point_y;
    } cmd_t;

    typedef struct packed {
        logic               found;
        logic [POINT_W-1:0] match_x;
        logic [POINT_W-1:0] match_y;
        logic [INDEX_W-1:0] match_index;
        logic               store_overflowed;
    } rsp_t;

endpackage

>>> hw/rtl/epm_ram.sv
module epm_ram
    import epm_pkg::*;
#(
    parameter int WIDTH = 2 * POINT_W,
    parameter int DEPTH = DEF_MAX_POINTS
)
(
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hw/rtl/epipolar_correspondence_match.sv
// Epipolar nearest-point matcher. Candidate points (unsigned Q12.4) are
// appended to a store of MAX_POINTS entries; a query point forms the line
// [x y 1]*F and returns the first stored point of least distance lying
// strictly within match_radius, together with the sticky overflow mark.
// Clear and append are accepted back to back. A query stalls the input
// side while it scans the stored points, and longer while an earlier
// result still waits: all products go through one shared 33x33 signed
// multiplier feeding a 128-bit accumulator, which first sets up the line
// and the threshold r^2*(a^2+b^2); each candidate then takes four
// multiply-accumulates for the distance, one step for its magnitude,
// three for its square and one to compare, and a last state hands the
// result over. The result sits in an output register, so further items
// are accepted while it waits. The store needs no clearing pass: a fill
// count marks the valid entries.
module epipolar_correspondence_match
    import epm_pkg::*;
#(
    parameter int MAX_POINTS = DEF_MAX_POINTS,
    parameter int COEF_BITS  = DEF_COEF_BITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cmd_valid,
    output logic                     cmd_stall,
    input  cmd_t                     cmd,
    output logic                     rsp_valid,
    input  logic                     rsp_stall,
    output rsp_t                     rsp,
    input  logic                     cfg_we,
    input  logic [CFG_INDEX_W-1:0]   cfg_index,
    input  logic [3*COEF_BITS-1:0]   cfg_data
);

    localparam int ROW_W  = 3 * COEF_BITS;
    localparam int ADDR_W = MAX_POINTS > 1 ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = 128;
    localparam int LINE_W = 40;
    localparam int MAG_W  = 60;
    localparam int S_W    = 80;
    localparam int T_W    = 104;
    localparam int R2_W   = 2 * RADIUS_W;

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_R2   = 5'd1;
    localparam logic [4:0] ST_A0   = 5'd2;
    localparam logic [4:0] ST_A1   = 5'd3;
    localparam logic [4:0] ST_B0   = 5'd4;
    localparam logic [4:0] ST_B1   = 5'd5;
    localparam logic [4:0] ST_C0   = 5'd6;
    localparam logic [4:0] ST_C1   = 5'd7;
    localparam logic [4:0] ST_SQA  = 5'd8;
    localparam logic [4:0] ST_SQB  = 5'd9;
    localparam logic [4:0] ST_T0   = 5'd10;
    localparam logic [4:0] ST_T1   = 5'd11;
    localparam logic [4:0] ST_T2   = 5'd12;
    localparam logic [4:0] ST_TCAP = 5'd13;
    localparam logic [4:0] ST_N0   = 5'd14;
    localparam logic [4:0] ST_N1   = 5'd15;
    localparam logic [4:0] ST_N2   = 5'd16;
    localparam logic [4:0] ST_N3   = 5'd17;
    localparam logic [4:0] ST_MAG  = 5'd18;
    localparam logic [4:0] ST_SQM  = 5'd19;
    localparam logic [4:0] ST_CMP  = 5'd20;
    localparam logic [4:0] ST_OUT  = 5'd21;

    localparam logic [1:0] SH_0  = 2'd0;
    localparam logic [1:0] SH_32 = 2'd1;
    localparam logic [1:0] SH_64 = 2'd2;

    function automatic logic signed [MUL_W-1:0] coef_ext(
        input logic [ROW_W-1:0] row,
        input int               col
    );
        logic [COEF_BITS-1:0] v;
        v = row[col*COEF_BITS +: COEF_BITS];
        return {{(MUL_W-COEF_BITS){v[COEF_BITS-1]}}, v};
    endfunction

    // configuration
    logic [ROW_W-1:0]    f_row0_reg;
    logic [ROW_W-1:0]    f_row1_reg;
    logic [ROW_W-1:0]    f_row2_reg;
    logic [RADIUS_W-1:0] radius_reg;

    // control
    logic [4:0]       state_reg;
    logic [1:0]       step_reg;
    logic [CNT_W-1:0] count_reg;
    logic             overflow_reg;
    logic             found_reg;
    logic             rsp_valid_reg;
    logic [ADDR_W-1:0] idx_reg;

    // datapath
    logic [POINT_W-1:0]       x_reg;
    logic [POINT_W-1:0]       y_reg;
    logic [R2_W-1:0]          r2_reg;
    logic [LINE_W-1:0]        a_reg;
    logic [LINE_W-1:0]        b_reg;
    logic [LINE_W-1:0]        c_reg;
    logic [LINE_W-1:0]        mag_a_reg;
    logic [LINE_W-1:0]        mag_b_reg;
    logic [S_W-1:0]           s_reg;
    logic [T_W-1:0]           t_reg;
    logic [POINT_W-1:0]       px_reg;
    logic [POINT_W-1:0]       py_reg;
    logic [MAG_W-1:0]         m_reg;
    logic [MAG_W-1:0]         best_reg;
    logic [ADDR_W-1:0]        best_idx_reg;
    logic [POINT_W-1:0]       best_x_reg;
    logic [POINT_W-1:0]       best_y_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    rsp_t                     rsp_reg;

    // shared unit
    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [ACC_W-1:0]  prod_shifted;
    logic signed [ACC_W-1:0]  acc_init;
    logic                     acc_load;
    logic [1:0]               shift_sel;
    logic signed [MUL_W-1:0]  f2_c0;
    logic signed [MUL_W-1:0]  f2_c1;
    logic signed [MUL_W-1:0]  f2_c2;

    logic [MAG_W-1:0]         sq_val;
    logic [LINE_W-1:0]        line_mag;
    logic [63:0]              n_mag;
    logic                     hit;
    logic [CNT_W-1:0]         idx_plus;
    logic                     scan_last;
    logic [ADDR_W+INDEX_W-1:0] best_idx_wide;

    logic                     cmd_accept;
    logic                     rsp_load;
    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_raddr;
    logic [2*POINT_W-1:0]     ram_rdata;

    assign cmd_stall  = (state_reg != ST_IDLE);
    assign cmd_accept = cmd_valid && !cmd_stall;
    assign rsp_valid  = rsp_valid_reg;
    assign rsp        = rsp_reg;
    assign rsp_load   = (state_reg == ST_OUT) && (!rsp_valid_reg || !rsp_stall);

    assign ram_we = cmd_accept && (cmd.opcode == OP_APPEND)
                    && (count_reg < CNT_W'(MAX_POINTS));

    epm_ram #(
        .WIDTH (2 * POINT_W),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata ({cmd.point_x, cmd.point_y}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign f2_c0 = coef_ext(f_row2_reg, 0);
    assign f2_c1 = coef_ext(f_row2_reg, 1);
    assign f2_c2 = coef_ext(f_row2_reg, 2);

    assign line_mag  = acc_reg[LINE_W-1] ? (LINE_W'(0) - acc_reg[LINE_W-1:0])
                                         : acc_reg[LINE_W-1:0];
    assign n_mag     = acc_reg[63] ? (64'd0 - acc_reg[63:0]) : acc_reg[63:0];
    assign hit       = acc_reg[ACC_W-1:0] < {{(ACC_W-T_W){1'b0}}, t_reg};
    assign idx_plus  = CNT_W'(idx_reg) + CNT_W'(1);
    assign scan_last = (idx_plus == count_reg);
    assign best_idx_wide = {{INDEX_W{1'b0}}, best_idx_reg};

    always_comb
    begin
        ram_raddr = idx_reg;
        if (state_reg == ST_TCAP)
        begin
            ram_raddr = '0;
        end
        else if (state_reg == ST_CMP)
        begin
            ram_raddr = idx_plus[ADDR_W-1:0];
        end
    end

    // operand select for the shared multiply-accumulate
    always_comb
    begin
        mul_a     = '0;
        mul_b     = '0;
        acc_load  = 1'b0;
        acc_init  = '0;
        shift_sel = SH_0;
        sq_val    = m_reg;
        if (state_reg == ST_SQA)
        begin
            sq_val = {{(MAG_W-LINE_W){1'b0}}, mag_a_reg};
        end
        else if (state_reg == ST_SQB)
        begin
            sq_val = {{(MAG_W-LINE_W){1'b0}}, mag_b_reg};
        end
        unique case (state_reg)
            ST_R2:
            begin
                mul_a    = {{(MUL_W-RADIUS_W){1'b0}}, radius_reg};
                mul_b    = {{(MUL_W-RADIUS_W){1'b0}}, radius_reg};
                acc_load = 1'b1;
            end
            ST_A0, ST_B0, ST_C0:
            begin
                mul_a    = {{(MUL_W-POINT_W){1'b0}}, x_reg};
                acc_load = 1'b1;
                if (state_reg == ST_A0)
                begin
                    mul_b    = coef_ext(f_row0_reg, 0);
                    acc_init = {{(ACC_W-MUL_W){f2_c0[MUL_W-1]}}, f2_c0};
                end
                else if (state_reg == ST_B0)
                begin
                    mul_b    = coef_ext(f_row0_reg, 1);
                    acc_init = {{(ACC_W-MUL_W){f2_c1[MUL_W-1]}}, f2_c1};
                end
                else
                begin
                    mul_b    = coef_ext(f_row0_reg, 2);
                    acc_init = {{(ACC_W-MUL_W){f2_c2[MUL_W-1]}}, f2_c2};
                end
            end
            ST_A1:
            begin
                mul_a = {{(MUL_W-POINT_W){1'b0}}, y_reg};
                mul_b = coef_ext(f_row1_reg, 0);
            end
            ST_B1:
            begin
                mul_a = {{(MUL_W-POINT_W){1'b0}}, y_reg};
                mul_b = coef_ext(f_row1_reg, 1);
            end
            ST_C1:
            begin
                mul_a = {{(MUL_W-POINT_W){1'b0}}, y_reg};
                mul_b = coef_ext(f_row1_reg, 2);
            end
            ST_SQA, ST_SQB, ST_SQM:
            begin
                // v^2 = lo*lo + 2*hi*lo<<32 + hi*hi<<64
                case (step_reg)
                    2'd0:
                    begin
                        mul_a    = {1'b0, sq_val[31:0]};
                        mul_b    = {1'b0, sq_val[31:0]};
                        acc_load = (state_reg != ST_SQB);
                    end
                    2'd1:
                    begin
                        mul_a     = {{(MUL_W-MAG_W+31){1'b0}}, sq_val[MAG_W-1:32], 1'b0};
                        mul_b     = {1'b0, sq_val[31:0]};
                        shift_sel = SH_32;
                    end
                    default:
                    begin
                        mul_a     = {{(MUL_W-MAG_W+32){1'b0}}, sq_val[MAG_W-1:32]};
                        mul_b     = {{(MUL_W-MAG_W+32){1'b0}}, sq_val[MAG_W-1:32]};
                        shift_sel = SH_64;
                    end
                endcase
            end
            ST_T0:
            begin
                mul_a    = {1'b0, acc_reg[31:0]};
                mul_b    = {{(MUL_W-R2_W){1'b0}}, r2_reg};
                acc_load = 1'b1;
            end
            ST_T1:
            begin
                mul_a     = {1'b0, s_reg[63:32]};
                mul_b     = {{(MUL_W-R2_W){1'b0}}, r2_reg};
                shift_sel = SH_32;
            end
            ST_T2:
            begin
                mul_a     = {{(MUL_W-S_W+64){1'b0}}, s_reg[S_W-1:64]};
                mul_b     = {{(MUL_W-R2_W){1'b0}}, r2_reg};
                shift_sel = SH_64;
            end
            ST_N0:
            begin
                // start from 16*c
                mul_a    = {1'b0, a_reg[31:0]};
                mul_b    = {{(MUL_W-POINT_W){1'b0}}, ram_rdata[2*POINT_W-1:POINT_W]};
                acc_load = 1'b1;
                acc_init = {{(ACC_W-LINE_W-4){c_reg[LINE_W-1]}}, c_reg, 4'b0000};
            end
            ST_N1:
            begin
                mul_a     = {{(MUL_W-LINE_W+32){a_reg[LINE_W-1]}}, a_reg[LINE_W-1:32]};
                mul_b     = {{(MUL_W-POINT_W){1'b0}}, px_reg};
                shift_sel = SH_32;
            end
            ST_N2:
            begin
                mul_a = {1'b0, b_reg[31:0]};
                mul_b = {{(MUL_W-POINT_W){1'b0}}, py_reg};
            end
            ST_N3:
            begin
                mul_a     = {{(MUL_W-LINE_W+32){b_reg[LINE_W-1]}}, b_reg[LINE_W-1:32]};
                mul_b     = {{(MUL_W-POINT_W){1'b0}}, py_reg};
                shift_sel = SH_32;
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    assign prod     = mul_a * mul_b;
    assign prod_ext = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};

    always_comb
    begin
        case (shift_sel)
            SH_32:   prod_shifted = prod_ext <<< 32;
            SH_64:   prod_shifted = prod_ext <<< 64;
            default: prod_shifted = prod_ext;
        endcase
        acc_next = (acc_load ? acc_init : acc_reg) + prod_shifted;
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (cmd_accept)
        begin
            x_reg <= cmd.point_x;
            y_reg <= cmd.point_y;
        end
        unique case (state_reg)
            ST_A0:
            begin
                r2_reg <= acc_reg[R2_W-1:0];
            end
            ST_B0:
            begin
                a_reg     <= acc_reg[LINE_W-1:0];
                mag_a_reg <= line_mag;
            end
            ST_C0:
            begin
                b_reg     <= acc_reg[LINE_W-1:0];
                mag_b_reg <= line_mag;
            end
            ST_SQA:
            begin
                if (step_reg == 2'd0)
                begin
                    c_reg <= acc_reg[LINE_W-1:0];
                end
            end
            ST_T0:
            begin
                s_reg <= acc_reg[S_W-1:0];
            end
            ST_TCAP:
            begin
                t_reg <= acc_reg[T_W-1:0];
            end
            ST_N0:
            begin
                px_reg <= ram_rdata[2*POINT_W-1:POINT_W];
                py_reg <= ram_rdata[POINT_W-1:0];
            end
            ST_MAG:
            begin
                m_reg <= n_mag[MAG_W-1:0];
            end
            ST_CMP:
            begin
                if (hit && (!found_reg || (m_reg < best_reg)))
                begin
                    best_reg     <= m_reg;
                    best_idx_reg <= idx_reg;
                    best_x_reg   <= px_reg;
                    best_y_reg   <= py_reg;
                end
            end
            default:
            begin
            end
        endcase
        if (rsp_load)
        begin
            rsp_reg.found            <= found_reg;
            rsp_reg.match_x          <= found_reg ? best_x_reg : '0;
            rsp_reg.match_y          <= found_reg ? best_y_reg : '0;
            rsp_reg.match_index      <= found_reg ? best_idx_wide[INDEX_W-1:0] : '0;
            rsp_reg.store_overflowed <= overflow_reg;
        end
    end

    // control and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_row0_reg    <= '0;
            f_row1_reg    <= '0;
            f_row2_reg    <= '0;
            radius_reg    <= RADIUS_RESET;
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            count_reg     <= '0;
            overflow_reg  <= 1'b0;
            found_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_F_ROW0: f_row0_reg <= cfg_data;
                    CFG_F_ROW1: f_row1_reg <= cfg_data;
                    CFG_F_ROW2: f_row2_reg <= cfg_data;
                    CFG_RADIUS: radius_reg <= cfg_data[RADIUS_W-1:0];
                endcase
            end

            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_accept)
                    begin
                        unique case (cmd.opcode)
                            OP_CLEAR:
                            begin
                                count_reg    <= '0;
                                overflow_reg <= 1'b0;
                            end
                            OP_APPEND:
                            begin
                                if (count_reg < CNT_W'(MAX_POINTS))
                                begin
                                    count_reg <= count_reg + CNT_W'(1);
                                end
                                else
                                begin
                                    overflow_reg <= 1'b1;
                                end
                            end
                            OP_QUERY:
                            begin
                                state_reg <= ST_R2;
                            end
                            default:
                            begin
                                // unused opcode: drop the item
                            end
                        endcase
                    end
                end
                ST_R2:   state_reg <= ST_A0;
                ST_A0:   state_reg <= ST_A1;
                ST_A1:   state_reg <= ST_B0;
                ST_B0:   state_reg <= ST_B1;
                ST_B1:   state_reg <= ST_C0;
                ST_C0:   state_reg <= ST_C1;
                ST_C1:
                begin
                    state_reg <= ST_SQA;
                    step_reg  <= '0;
                end
                ST_SQA, ST_SQB, ST_SQM:
                begin
                    if (step_reg == 2'd2)
                    begin
                        step_reg <= '0;
                        if (state_reg == ST_SQA)
                        begin
                            state_reg <= ST_SQB;
                        end
                        else if (state_reg == ST_SQB)
                        begin
                            state_reg <= ST_T0;
                        end
                        else
                        begin
                            state_reg <= ST_CMP;
                        end
                    end
                    else
                    begin
                        step_reg <= step_reg + 2'd1;
                    end
                end
                ST_T0:   state_reg <= ST_T1;
                ST_T1:   state_reg <= ST_T2;
                ST_T2:   state_reg <= ST_TCAP;
                ST_TCAP:
                begin
                    found_reg <= 1'b0;
                    idx_reg   <= '0;
                    state_reg <= (count_reg == '0) ? ST_OUT : ST_N0;
                end
                ST_N0:   state_reg <= ST_N1;
                ST_N1:   state_reg <= ST_N2;
                ST_N2:   state_reg <= ST_N3;
                ST_N3:   state_reg <= ST_MAG;
                ST_MAG:
                begin
                    state_reg <= ST_SQM;
                    step_reg  <= '0;
                end
                ST_CMP:
                begin
                    if (hit)
                    begin
                        found_reg <= 1'b1;
                    end
                    if (scan_last)
                    begin
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        idx_reg   <= idx_plus[ADDR_W-1:0];
                        state_reg <= ST_N0;
                    end
                end
                ST_OUT:
                begin
                    // hold until the output register is free
                    if (rsp_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
